FILE: rtl/vta_pkg.sv
// Shared types and constants for the per-CPU virtual-time admission block.
// Used by vta_min_scan and per_cpu_virtual_time_admission_top; no dependencies.

package vta_pkg;

   localparam int NUM_CPUS_DEFAULT = 8;

   localparam int TIME_W  = 64;
   localparam int BYTES_W = 24;
   localparam int CPU_W   = 3;
   localparam int PEND_W  = 8;
   localparam int TICK_W  = 2;

   // The tick counter counts 0, 1, 2; the third tick kicks the queues and wraps.
   localparam logic [TICK_W-1:0] TICK_LAST = 2'd2;

   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_SCAN_DRAIN,
      ST_SCAN_DONE,
      ST_MIN_RD,
      ST_MIN_WAIT,
      ST_CPU_RD,
      ST_CPU_WAIT,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   // Control from the sequencer to the minimum scan unit.
   typedef struct packed {
      logic clear;
      logic cmp_en;
      logic cmp_working;
   } scan_ctl_type;

   // Running result of the minimum scan.
   typedef struct packed {
      logic              found;
      logic [TIME_W-1:0] best;
   } scan_res_type;

endpackage

FILE: rtl/per_cpu_virtual_time_admission_top.sv
// Per-CPU virtual-time admission control, top level: sequencer, flag registers,
// virtual-time RAM (vta_ram) and minimum scan unit (vta_min_scan). Uses vta_pkg.
//
// Usage:
//   The req_ channel carries one transaction per admission request or timer
//   tick; the rsp_ channel returns exactly one transaction (granted,
//   kick_queues) for each. csr_write_enable/csr_write_data set the
//   scheduling enable bit; write it only while the block is idle.
//   The block handles one transaction at a time. Virtual times live
//   in a one-read, one-write RAM; the steps per transaction are:
//     - scheduling disabled or CPU out of range: no RAM access,
//     - request with a cached minimum: read the minimum, then the CPU entry,
//     - request with an empty cache: a scan of all entries (one entry scanned
//       per cycle through a single comparator), then the CPU entry,
//     - tick: scan, then a sweep that writes each pending, non-working entry.
//   A finished result waits in the output register while rsp_stall is high;
//   the next request is taken once that result has been loaded.
//   Reset clears all flags, the minimum cache, the tick counter and the
//   enable bit. Virtual times are not cleared: an entry is always written
//   when its CPU starts working, before it is ever read.

module per_cpu_virtual_time_admission_top #(
   parameter int NUM_CPUS = vta_pkg::NUM_CPUS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  logic [vta_pkg::CPU_W-1:0]   req_cpu_index,
   input  logic                        req_is_write,
   input  logic [vta_pkg::BYTES_W-1:0] req_byte_count,
   input  logic [vta_pkg::PEND_W-1:0]  req_pending_mask,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_granted,
   output logic                        rsp_kick_queues,
   input  logic                        csr_write_enable,
   input  logic                        csr_write_data
);
   import vta_pkg::*;

   localparam int IDX_W = $clog2(NUM_CPUS);
   localparam int CW    = (IDX_W > CPU_W) ? IDX_W : CPU_W;
   localparam int PW    = (NUM_CPUS > PEND_W) ? NUM_CPUS : PEND_W;
   localparam int INC_W = BYTES_W + 2;
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_CPUS - 1);
   localparam logic [31:0]      NUM_CPUS_U = 32'(NUM_CPUS);

   state_type            state_ff, state_in;
   logic                 enable_ff, enable_in;
   logic                 op_ff, op_in;
   logic [CPU_W-1:0]     cpu_ff, cpu_in;
   logic                 wr_ff, wr_in;
   logic [BYTES_W-1:0]   bytes_ff, bytes_in;
   logic [PEND_W-1:0]    pend_ff, pend_in;
   logic [NUM_CPUS-1:0]  working_ff, working_in;
   logic [NUM_CPUS-1:0]  busy_ff, busy_in;
   logic [IDX_W-1:0]     min_idx_ff, min_idx_in;
   logic                 min_valid_ff, min_valid_in;
   logic [TICK_W-1:0]    tick_cnt_ff, tick_cnt_in;
   logic [TIME_W-1:0]    minv_ff, minv_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic                 scan_rd_ff, scan_rd_in;
   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 res_granted_ff, res_granted_in;
   logic                 res_kick_ff, res_kick_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_granted_ff, rsp_granted_in;
   logic                 rsp_kick_ff, rsp_kick_in;

   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [TIME_W-1:0]    ram_wr_data;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [TIME_W-1:0]    ram_rd_data;

   scan_ctl_type         scan_ctl;
   scan_res_type         scan_res;
   logic [IDX_W-1:0]     scan_best_idx;

   logic [CW-1:0]        cpu_ext;
   logic [IDX_W-1:0]     cpu_idx;
   logic                 cpu_in_range;
   logic [PW-1:0]        pend_ext;
   logic [NUM_CPUS-1:0]  pend_vec;
   logic [INC_W-1:0]     inc;

   assign cpu_ext      = CW'(cpu_ff);
   assign cpu_idx      = cpu_ext[IDX_W-1:0];
   assign cpu_in_range = 32'(cpu_ff) < NUM_CPUS_U;

   // CPUs past the width of the pending mask are never pending.
   assign pend_ext = PW'(pend_ff);
   assign pend_vec = pend_ext[NUM_CPUS-1:0];

   // Weight 2 for a read, 3 for a write: twice the length plus the length.
   assign inc = {1'b0, bytes_ff, 1'b0} + (wr_ff ? INC_W'(bytes_ff) : '0);

   vta_ram #(
      .WIDTH (TIME_W),
      .DEPTH (NUM_CPUS)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   vta_min_scan #(
      .NUM_CPUS (NUM_CPUS)
   ) u_min_scan (
      .clock    (clock),
      .reset    (reset),
      .scan_ctl (scan_ctl),
      .cmp_idx  (scan_idx_ff),
      .rd_data  (ram_rd_data),
      .scan_res (scan_res),
      .best_idx (scan_best_idx)
   );

   always_comb begin
      state_in       = state_ff;
      enable_in      = csr_write_enable ? csr_write_data : enable_ff;
      op_in          = op_ff;
      cpu_in         = cpu_ff;
      wr_in          = wr_ff;
      bytes_in       = bytes_ff;
      pend_in        = pend_ff;
      working_in     = working_ff;
      busy_in        = busy_ff;
      min_idx_in     = min_idx_ff;
      min_valid_in   = min_valid_ff;
      tick_cnt_in    = tick_cnt_ff;
      minv_in        = minv_ff;
      cnt_in         = cnt_ff;
      scan_rd_in     = 1'b0;
      scan_idx_in    = scan_idx_ff;
      res_granted_in = res_granted_ff;
      res_kick_in    = res_kick_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_granted_in = rsp_granted_ff;
      rsp_kick_in    = rsp_kick_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = cpu_idx;
      ram_wr_data    = minv_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = cnt_ff;
      scan_ctl.clear       = 1'b0;
      scan_ctl.cmp_en      = scan_rd_ff;
      scan_ctl.cmp_working = working_ff[scan_idx_ff];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               cpu_in   = req_cpu_index;
               wr_in    = req_is_write;
               bytes_in = req_byte_count;
               pend_in  = req_pending_mask;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            res_granted_in = 1'b0;
            res_kick_in    = 1'b0;
            cnt_in         = '0;
            if (op_ff == OP_REQUEST) begin
               if (!enable_ff) begin
                  res_granted_in = 1'b1;
                  state_in       = ST_FINISH;
               end else if (!cpu_in_range) begin
                  state_in = ST_FINISH;
               end else if (min_valid_ff) begin
                  state_in = ST_MIN_RD;
               end else begin
                  scan_ctl.clear = 1'b1;
                  state_in       = ST_SCAN;
               end
            end else begin
               if (!enable_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  // A tick always rebuilds the minimum cache.
                  min_valid_in   = 1'b0;
                  scan_ctl.clear = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = cnt_ff;
            scan_rd_in  = 1'b1;
            scan_idx_in = cnt_ff;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_SCAN_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_SCAN_DRAIN: begin
            state_in = ST_SCAN_DONE;
         end

         ST_SCAN_DONE: begin
            cnt_in = '0;
            if (scan_res.found) begin
               min_valid_in = 1'b1;
               min_idx_in   = scan_best_idx;
               minv_in      = scan_res.best;
            end else begin
               minv_in = '0;
            end
            state_in = (op_ff == OP_TICK) ? ST_SWEEP : ST_CPU_RD;
         end

         ST_MIN_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = min_idx_ff;
            state_in    = ST_MIN_WAIT;
         end

         ST_MIN_WAIT: begin
            minv_in  = ram_rd_data;
            state_in = ST_CPU_RD;
         end

         ST_CPU_RD: begin
            if (!working_ff[cpu_idx]) begin
               // Joining at the minimum always passes the check, so the
               // joined time and the charge go out in one write.
               working_in[cpu_idx] = 1'b1;
               busy_in[cpu_idx]    = 1'b1;
               ram_wr_en           = 1'b1;
               ram_wr_addr         = cpu_idx;
               ram_wr_data         = minv_ff + TIME_W'(inc);
               res_granted_in      = 1'b1;
               state_in            = ST_FINISH;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cpu_idx;
               state_in    = ST_CPU_WAIT;
            end
         end

         ST_CPU_WAIT: begin
            if (ram_rd_data <= minv_ff) begin
               ram_wr_en      = 1'b1;
               ram_wr_addr    = cpu_idx;
               ram_wr_data    = ram_rd_data + TIME_W'(inc);
               res_granted_in = 1'b1;
            end
            state_in = ST_FINISH;
         end

         ST_SWEEP: begin
            if (pend_vec[cnt_ff] && !working_ff[cnt_ff]) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = cnt_ff;
               ram_wr_data = minv_ff;
            end
            if (cnt_ff == LAST_IDX) begin
               // A pending CPU works and stays busy; an idle one that is not
               // pending stops working; a busy one only goes idle.
               working_in = pend_vec | (working_ff & busy_ff);
               busy_in    = pend_vec;
               if (tick_cnt_ff == TICK_LAST) begin
                  tick_cnt_in = '0;
                  res_kick_in = 1'b1;
               end else begin
                  tick_cnt_in = tick_cnt_ff + 1'b1;
               end
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_kick_in    = res_kick_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         working_ff   <= '0;
         busy_ff      <= '0;
         min_idx_ff   <= '0;
         min_valid_ff <= 1'b0;
         tick_cnt_ff  <= '0;
         scan_rd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         working_ff   <= working_in;
         busy_ff      <= busy_in;
         min_idx_ff   <= min_idx_in;
         min_valid_ff <= min_valid_in;
         tick_cnt_ff  <= tick_cnt_in;
         scan_rd_ff   <= scan_rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      cpu_ff         <= cpu_in;
      wr_ff          <= wr_in;
      bytes_ff       <= bytes_in;
      pend_ff        <= pend_in;
      minv_ff        <= minv_in;
      cnt_ff         <= cnt_in;
      scan_idx_ff    <= scan_idx_in;
      res_granted_ff <= res_granted_in;
      res_kick_ff    <= res_kick_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_kick_ff    <= rsp_kick_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_granted_ff;
   assign rsp_kick_queues = rsp_kick_ff;

   a_grant_or_kick : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_granted_ff && rsp_kick_ff))
      else $error("result carries both a grant and a kick");

   a_tick_range : assert property (@(posedge clock) disable iff (reset)
      tick_cnt_ff <= TICK_LAST)
      else $error("tick counter out of range");

   a_rsp_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result presented outside the finish step");

   a_cpu_read_working : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CPU_WAIT) |-> working_ff[cpu_idx])
      else $error("virtual time read for a CPU that is not working");

   a_cache_in_range : assert property (@(posedge clock) disable iff (reset)
      min_valid_ff |-> (32'(min_idx_ff) < NUM_CPUS_U))
      else $error("cached minimum entry out of range");

endmodule

FILE: rtl/vta_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.

module vta_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/vta_min_scan.sv
// Minimum search unit: one comparator that walks the virtual-time RAM read data
// and keeps the smallest time among working entries. Depends on vta_pkg.

module vta_min_scan #(
   parameter int NUM_CPUS = vta_pkg::NUM_CPUS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  vta_pkg::scan_ctl_type       scan_ctl,
   input  logic [$clog2(NUM_CPUS)-1:0] cmp_idx,
   input  logic [vta_pkg::TIME_W-1:0]  rd_data,
   output vta_pkg::scan_res_type       scan_res,
   output logic [$clog2(NUM_CPUS)-1:0] best_idx
);
   import vta_pkg::*;

   localparam int IDX_W = $clog2(NUM_CPUS);

   logic              found_ff, found_in;
   logic [TIME_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic              take;

   // Strict less-than against an all-ones start: an entry at the top time is
   // never picked, so a scan over only such entries finds nothing.
   assign take = scan_ctl.cmp_en && scan_ctl.cmp_working && (rd_data < best_ff);

   always_comb begin
      found_in    = found_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (scan_ctl.clear) begin
         found_in = 1'b0;
         best_in  = '1;
      end else if (take) begin
         found_in    = 1'b1;
         best_in     = rd_data;
         best_idx_in = cmp_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   assign scan_res.found = found_ff;
   assign scan_res.best  = best_ff;
   assign best_idx       = best_idx_ff;

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      scan_ctl.clear |=> !found_ff)
      else $error("scan result not cleared");

   a_found_sticky : assert property (@(posedge clock) disable iff (reset)
      (found_ff && !scan_ctl.clear) |=> found_ff)
      else $error("scan lost its minimum");

   a_best_shrinks : assert property (@(posedge clock) disable iff (reset)
      (found_ff && !scan_ctl.clear) |=> (best_ff <= $past(best_ff)))
      else $error("scan minimum grew");

endmodule
